// File: src/tgu_pkg.sv
// Shared types and constants for the trilinear grid upsampler.
// Depends on nothing; imported by the top level and the grid memory.
package tgu_pkg;

   // Defaults of the top level's parameters
   localparam int MAX_GRID_DIM_DEF = 16;
   localparam int SAMPLE_BITS_DEF  = 16;

   // Fixed widths of the item fields
   localparam int COORD_W = 24;
   localparam int LOCAL_W = COORD_W + 1;
   localparam int IDX_W   = 12;
   localparam int VAL_W   = 16;
   localparam int OFF_W   = 8;
   localparam int SHIFT_W = 3;
   localparam int GDIM_W  = 5;

   // Register indexes on the configuration port
   typedef enum logic [2:0] {
      REG_ORIGIN_X   = 3'd0,
      REG_ORIGIN_Y   = 3'd1,
      REG_ORIGIN_Z   = 3'd2,
      REG_GRID_DIM   = 3'd3,
      REG_STEP_SHIFT = 3'd4
   } reg_index_type;

   localparam logic [GDIM_W-1:0]  GRID_DIM_RST   = 5'd10;
   localparam logic [SHIFT_W-1:0] STEP_SHIFT_RST = 3'd2;

endpackage

// File: src/tgu_grid_mem.sv
// Grid sample store: four copies, each with two registered read ports.
// Depends on tgu_pkg; one write port shared by all copies.
module tgu_grid_mem
   import tgu_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int SB    = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic                 we,
   input  logic [AW-1:0]        waddr,
   input  logic [SB-1:0]        wdata,
   input  logic [7:0][AW-1:0]   raddr,
   output logic [7:0][SB-1:0]   rdata
);

   for (genvar k = 0; k < 4; k++) begin : g_copy
      logic [SB-1:0] mem [DEPTH];

      // Write every copy, read two corners from this copy
      always_ff @(posedge clock) begin
         if (we) begin
            mem[waddr] <= wdata;
         end
         if (en) begin
            rdata[2*k]   <= mem[raddr[2*k]];
            rdata[2*k+1] <= mem[raddr[2*k+1]];
         end
      end
   end

endmodule

// File: src/trilinear_grid_upsampler.sv
// Trilinear grid upsampler top level: CSRs, address pipeline and lerp pipeline.
// Depends on tgu_pkg and tgu_grid_mem.
//
//   channel  | direction | handshake            | payload
//   req      | in        | req_valid/req_ready  | mode, world_x/y/z, sample_index/value
//   rsp      | out       | rsp_valid/rsp_ready  | interp_value (queries only)
//   csr      | in        | APB psel/penable     | origin_x/y/z, grid_dim, step_shift
//
// One item per cycle while rsp is not stalled. A query passes eight register stages:
// local coordinate, cell, offset, base address, memory read, then one lerp axis per
// stage. Reset is synchronous, clears the valid bits and loads the configuration
// registers with their reset values; payload registers and the grid store are not
// cleared. A stall on rsp holds the whole pipe.
module trilinear_grid_upsampler
   import tgu_pkg::*;
#(
   parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_mode,
   input  logic signed [COORD_W-1:0] req_world_x,
   input  logic signed [COORD_W-1:0] req_world_y,
   input  logic signed [COORD_W-1:0] req_world_z,
   input  logic [IDX_W-1:0]          req_sample_index,
   input  logic signed [VAL_W-1:0]   req_sample_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VAL_W-1:0]   rsp_interp_value,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [4:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int SB    = SAMPLE_BITS;
   localparam int DEPTH = MAX_GRID_DIM * MAX_GRID_DIM * MAX_GRID_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_GRID_DIM);
   localparam int DIM_W = $clog2(MAX_GRID_DIM + 1);
   localparam int RW    = (SB > 17) ? SB : 17;

   // One lerp: a + floor((b-a)*r / 2^s)
   function automatic logic signed [SB-1:0] lerp_q(input logic signed [SB-1:0] a,
                                                    input logic signed [SB-1:0] b,
                                                    input logic [OFF_W-1:0] r,
                                                    input logic [SHIFT_W-1:0] s);
      logic signed [SB:0]         d;
      logic signed [SB+OFF_W+1:0] p;
      logic signed [SB+OFF_W+1:0] q;
      d = (SB+1)'(b) - (SB+1)'(a);
      p = (SB+OFF_W+2)'(d) * (SB+OFF_W+2)'($signed({1'b0, r}));
      q = p >>> s;
      return SB'(q + (SB+OFF_W+2)'(a));
   endfunction

   // Configuration registers
   logic signed [COORD_W-1:0] org_x_ff, org_y_ff, org_z_ff;
   logic [GDIM_W-1:0]         gdim_ff;
   logic [SHIFT_W-1:0]        shift_ff;
   logic                      csr_wr;
   reg_index_type             csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
         org_z_ff <= '0;
         gdim_ff  <= GRID_DIM_RST;
         shift_ff <= STEP_SHIFT_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ORIGIN_X:   org_x_ff <= csr_pwdata[COORD_W-1:0];
            REG_ORIGIN_Y:   org_y_ff <= csr_pwdata[COORD_W-1:0];
            REG_ORIGIN_Z:   org_z_ff <= csr_pwdata[COORD_W-1:0];
            REG_GRID_DIM:   gdim_ff  <= csr_pwdata[GDIM_W-1:0];
            REG_STEP_SHIFT: shift_ff <= csr_pwdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ORIGIN_X:   csr_prdata = {{(32-COORD_W){1'b0}}, org_x_ff};
         REG_ORIGIN_Y:   csr_prdata = {{(32-COORD_W){1'b0}}, org_y_ff};
         REG_ORIGIN_Z:   csr_prdata = {{(32-COORD_W){1'b0}}, org_z_ff};
         REG_GRID_DIM:   csr_prdata = {{(32-GDIM_W){1'b0}}, gdim_ff};
         REG_STEP_SHIFT: csr_prdata = {{(32-SHIFT_W){1'b0}}, shift_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // Saturate the grid size and derive its square
   logic [DIM_W-1:0] dim;
   logic [CW-1:0]    dim_m2;
   logic [AW-1:0]    dsq_in, dsq_ff;
   logic [OFF_W:0]   step;

   always_comb begin
      if (gdim_ff < GDIM_W'(2)) begin
         dim = DIM_W'(2);
      end else if (6'(gdim_ff) > 6'(MAX_GRID_DIM)) begin
         dim = DIM_W'(MAX_GRID_DIM);
      end else begin
         dim = DIM_W'(gdim_ff);
      end
      dim_m2 = CW'(dim - DIM_W'(2));
      dsq_in = AW'(dim) * AW'(dim);
      step   = (OFF_W+1)'(1) << shift_ff;
   end

   always_ff @(posedge clock) begin
      dsq_ff <= dsq_in;
   end

   // Global advance: the whole pipe moves unless the result is held
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // Stage 1: local coordinates, load payload
   logic                      s1_v_ff, s1_q_ff;
   logic signed [LOCAL_W-1:0] s1_lx_ff, s1_ly_ff, s1_lz_ff;
   logic [IDX_W-1:0]          s1_idx_ff;
   logic [SB-1:0]             s1_val_ff;

   // Stage 2: clamped cells
   logic                      s2_v_ff, s2_q_ff;
   logic signed [LOCAL_W-1:0] s2_lx_ff, s2_ly_ff, s2_lz_ff;
   logic [CW-1:0]             s2_cx_ff, s2_cy_ff, s2_cz_ff;
   logic [CW-1:0]             s2_cx_in, s2_cy_in, s2_cz_in;
   logic [IDX_W-1:0]          s2_idx_ff;
   logic [SB-1:0]             s2_val_ff;

   // Stage 3: offsets and partial index
   logic                      s3_v_ff, s3_q_ff;
   logic [CW-1:0]             s3_cx_ff;
   logic [AW-1:0]             s3_pyz_ff;
   logic [OFF_W-1:0]          s3_fx_ff, s3_fy_ff, s3_fz_ff;
   logic [OFF_W-1:0]          s3_fx_in, s3_fy_in, s3_fz_in;
   logic [IDX_W-1:0]          s3_idx_ff;
   logic [SB-1:0]             s3_val_ff;

   // Stage 4: base index
   logic                      s4_v_ff, s4_q_ff;
   logic [AW-1:0]             s4_base_ff;
   logic [OFF_W-1:0]          s4_fx_ff, s4_fy_ff, s4_fz_ff;
   logic [IDX_W-1:0]          s4_idx_ff;
   logic [SB-1:0]             s4_val_ff;

   // Stage 5: corner samples from the store
   logic                      s5_v_ff, s5_q_ff;
   logic [OFF_W-1:0]          s5_fx_ff, s5_fy_ff, s5_fz_ff;
   logic [7:0][SB-1:0]        s5_corner;

   // Stage 6: x lerps; stage 7: y lerps; stage 8: z lerp
   logic                      s6_v_ff, s6_q_ff, s7_v_ff, s7_q_ff;
   logic [OFF_W-1:0]          s6_fy_ff, s6_fz_ff, s7_fz_ff;
   logic signed [SB-1:0]      s6_c00_ff, s6_c10_ff, s6_c01_ff, s6_c11_ff;
   logic signed [SB-1:0]      s7_c0_ff, s7_c1_ff;
   logic signed [SB-1:0]      zl;
   logic signed [RW-1:0]      zx;
   logic signed [VAL_W-1:0]   out_in, out_ff;
   logic                      out_v_ff;

   // Cell along one axis: floor of local / step, clamped to the edge cells
   function automatic logic [CW-1:0] cell_of(input logic signed [LOCAL_W-1:0] l,
                                             input logic [SHIFT_W-1:0] s,
                                             input logic [CW-1:0] lim);
      logic signed [LOCAL_W-1:0] q;
      q = l >>> s;
      if (q < 0) begin
         return '0;
      end else if (q > $signed(LOCAL_W'(lim))) begin
         return lim;
      end
      return CW'(q);
   endfunction

   // Offset in the cell, clamped to 0..step
   function automatic logic [OFF_W-1:0] off_of(input logic signed [LOCAL_W-1:0] l,
                                               input logic [CW-1:0] c,
                                               input logic [SHIFT_W-1:0] s,
                                               input logic [OFF_W:0] st);
      logic signed [LOCAL_W:0] r;
      r = (LOCAL_W+1)'(l) - $signed((LOCAL_W+1)'(c) << s);
      if (r < 0) begin
         return '0;
      end else if (r > $signed((LOCAL_W+1)'(st))) begin
         return OFF_W'(st);
      end
      return OFF_W'(r);
   endfunction

   always_comb begin
      s2_cx_in = cell_of(s1_lx_ff, shift_ff, dim_m2);
      s2_cy_in = cell_of(s1_ly_ff, shift_ff, dim_m2);
      s2_cz_in = cell_of(s1_lz_ff, shift_ff, dim_m2);
      s3_fx_in = off_of(s2_lx_ff, s2_cx_ff, shift_ff, step);
      s3_fy_in = off_of(s2_ly_ff, s2_cy_ff, shift_ff, step);
      s3_fz_in = off_of(s2_lz_ff, s2_cz_ff, shift_ff, step);
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         s6_v_ff  <= 1'b0;
         s7_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= req_valid;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         s4_v_ff  <= s3_v_ff;
         s5_v_ff  <= s4_v_ff;
         s6_v_ff  <= s5_v_ff;
         s7_v_ff  <= s6_v_ff;
         out_v_ff <= s7_v_ff && s7_q_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_q_ff   <= req_mode;
         s1_lx_ff  <= LOCAL_W'(req_world_x) - LOCAL_W'(org_x_ff);
         s1_ly_ff  <= LOCAL_W'(req_world_y) - LOCAL_W'(org_y_ff);
         s1_lz_ff  <= LOCAL_W'(req_world_z) - LOCAL_W'(org_z_ff);
         s1_idx_ff <= req_sample_index;
         s1_val_ff <= SB'(req_sample_value);

         s2_q_ff   <= s1_q_ff;
         s2_lx_ff  <= s1_lx_ff;
         s2_ly_ff  <= s1_ly_ff;
         s2_lz_ff  <= s1_lz_ff;
         s2_cx_ff  <= s2_cx_in;
         s2_cy_ff  <= s2_cy_in;
         s2_cz_ff  <= s2_cz_in;
         s2_idx_ff <= s1_idx_ff;
         s2_val_ff <= s1_val_ff;

         s3_q_ff   <= s2_q_ff;
         s3_cx_ff  <= s2_cx_ff;
         s3_pyz_ff <= AW'(s2_cy_ff) + AW'(dim) * AW'(s2_cz_ff);
         s3_fx_ff  <= s3_fx_in;
         s3_fy_ff  <= s3_fy_in;
         s3_fz_ff  <= s3_fz_in;
         s3_idx_ff <= s2_idx_ff;
         s3_val_ff <= s2_val_ff;

         s4_q_ff    <= s3_q_ff;
         s4_base_ff <= AW'(s3_cx_ff) + AW'(dim) * s3_pyz_ff;
         s4_fx_ff   <= s3_fx_ff;
         s4_fy_ff   <= s3_fy_ff;
         s4_fz_ff   <= s3_fz_ff;
         s4_idx_ff  <= s3_idx_ff;
         s4_val_ff  <= s3_val_ff;

         s5_q_ff  <= s4_q_ff;
         s5_fx_ff <= s4_fx_ff;
         s5_fy_ff <= s4_fy_ff;
         s5_fz_ff <= s4_fz_ff;

         s6_q_ff   <= s5_q_ff;
         s6_fy_ff  <= s5_fy_ff;
         s6_fz_ff  <= s5_fz_ff;
         s6_c00_ff <= lerp_q(s5_corner[0], s5_corner[1], s5_fx_ff, shift_ff);
         s6_c10_ff <= lerp_q(s5_corner[2], s5_corner[3], s5_fx_ff, shift_ff);
         s6_c01_ff <= lerp_q(s5_corner[4], s5_corner[5], s5_fx_ff, shift_ff);
         s6_c11_ff <= lerp_q(s5_corner[6], s5_corner[7], s5_fx_ff, shift_ff);

         s7_q_ff  <= s6_q_ff;
         s7_fz_ff <= s6_fz_ff;
         s7_c0_ff <= lerp_q(s6_c00_ff, s6_c10_ff, s6_fy_ff, shift_ff);
         s7_c1_ff <= lerp_q(s6_c01_ff, s6_c11_ff, s6_fy_ff, shift_ff);

         out_ff <= out_in;
      end
   end

   // Corner addresses: x step 1, y step dim, z step dim squared
   logic [7:0][AW-1:0] raddr;
   logic               mem_we;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         raddr[k] = s4_base_ff + AW'(k & 1) + ((k & 2) != 0 ? AW'(dim) : '0)
                    + ((k & 4) != 0 ? dsq_ff : '0);
      end
   end

   // Write a load into the store in the same stage that queries read it
   assign mem_we = adv && s4_v_ff && !s4_q_ff && (32'(s4_idx_ff) < DEPTH);

   tgu_grid_mem #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .SB    (SB)
   ) u_mem (
      .clock (clock),
      .en    (adv),
      .we    (mem_we),
      .waddr (AW'(s4_idx_ff)),
      .wdata (s4_val_ff),
      .raddr (raddr),
      .rdata (s5_corner)
   );

   // Final z lerp and saturation to Q1.15
   always_comb begin
      zl = lerp_q(s7_c0_ff, s7_c1_ff, s7_fz_ff, shift_ff);
      zx = RW'(zl);
      if (zx > $signed(RW'(32767))) begin
         out_in = 16'sh7fff;
      end else if (zx < -$signed(RW'(32768))) begin
         out_in = 16'sh8000;
      end else begin
         out_in = VAL_W'(zx);
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_interp_value = out_ff;

   // Hold the valid bits of stages one to seven while the result is stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable({s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff}))
      else $error("pipeline moved during stall");

   // A load never produces a result
   a_load: assert property (@(posedge clock) disable iff (reset)
      adv && s7_v_ff && !s7_q_ff |=> !rsp_valid)
      else $error("load produced a result");

   // No store write from a query stage
   a_we: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> s4_v_ff && !s4_q_ff && adv)
      else $error("store written by a query");

endmodule
